FILE: sv/srq_pkg.sv
// srq_pkg: shared types and codes for the sorted request queue
// holds the command and status codes, the entry type and the cell control struct
// no dependencies
package srq_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned PosW   = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [IdW-1:0]    id;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic   ins;   // insert takes effect this cycle
    logic   del;   // remove or pop takes effect this cycle
    entry_t key;   // new entry for insert, id is the match key for remove
  } cell_ctrl_t;

endpackage

FILE: sv/srq_if.sv
// srq_req_if and srq_rsp_if: valid/ready channels of the sorted request queue
// depends on srq_pkg for field widths
interface srq_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [srq_pkg::StampW-1:0]  stamp;
  logic [srq_pkg::IdW-1:0]     requester;

  modport source (output valid, mode, stamp, requester, input ready);
  modport sink   (input valid, mode, stamp, requester, output ready);
endinterface

interface srq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [srq_pkg::PosW-1:0]   position;
  logic [srq_pkg::IdW-1:0]    head_id;

  modport source (output valid, status, position, head_id, input ready);
  modport sink   (input valid, status, position, head_id, output ready);
endinterface

FILE: sv/srq_cell.sv
// srq_cell: one slot of the sorted row, holds one entry
// compares against the new request, takes new, left or right data on a shift
// depends on srq_pkg
module srq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  srq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                left_gt_i,
  input  srq_pkg::entry_t     left_i,
  input  srq_pkg::entry_t     right_i,
  input  logic                seen_i,
  output logic                gt_o,
  output logic                ins_here_o,
  output logic                first_o,
  output logic                seen_o,
  output srq_pkg::entry_t     entry_o
);

  srq_pkg::entry_t entry_q, entry_d;
  logic            match;

  // ordering is stamp first, then id: one compare on the packed pair
  assign gt_o       = valid_i && (ctrl_i.key > entry_q);
  assign ins_here_o = left_gt_i && !gt_o;
  assign match      = valid_i && (entry_q.id == ctrl_i.key.id);
  assign first_o    = match && !seen_i;
  assign seen_o     = seen_i || match;
  assign entry_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        entry_d = entry_q;
      end else if (left_gt_i) begin
        entry_d = ctrl_i.key;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del && seen_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

FILE: sv/srq_enc.sv
// srq_enc: one-hot to binary index encoder for the cell row
// no dependencies
module srq_enc #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 4
) (
  input  logic [N-1:0] oh_i,
  output logic [W-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int unsigned k = 0; k < N; k++) begin
      if (oh_i[k]) begin
        idx_o = idx_o | W'(k);
      end
    end
  end

endmodule

FILE: sv/sorted_request_queue.sv
// sorted_request_queue: up to DEPTH (stamp, id) entries kept in ascending order
// Usage:
//   req_i carries mode (insert, remove by id, pop head, clear), stamp and
//   requester; rsp_o returns status, position and head_id, one response
//   per request, in request order.
//   Every command is decided and applied in the cycle it is accepted: each
//   cell of the row compares itself against the request and takes its own,
//   the new, the left or the right entry. The response is held in an output
//   register and appears in the cycle after acceptance.
//   Throughput is one request per cycle while rsp_o is not stalled; the
//   single compare-and-shift pass across the cell row sets that figure.
//   When rsp_o is stalled, the held response stays and req_i.ready drops
//   until it is taken; a request is accepted in the same cycle the held
//   response leaves.
//   Reset empties the queue (occupancy zero) and drops any held response;
//   no clearing pass is needed, since slots at or above the occupancy are
//   never read.
// depends on srq_pkg, srq_if, srq_cell, srq_enc
module sorted_request_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srq_req_if.sink       req_i,
  srq_rsp_if.source     rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = srq_pkg::PosW;

  logic [CW-1:0]            occ_q, occ_d;
  logic                     rsp_valid_q;
  logic [1:0]               status_q, status_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic [srq_pkg::IdW-1:0]  head_q, head_d;

  logic                     accept;
  logic                     full, empty;
  srq_pkg::mode_e           mode;
  srq_pkg::cell_ctrl_t      ctrl;

  logic [DEPTH-1:0]         gt, ins_here, first;
  logic [DEPTH:0]           seen;
  srq_pkg::entry_t          ent [DEPTH];
  logic [IW-1:0]            ins_idx, rem_idx;
  logic [IW+PW-1:0]         ins_ext, rem_ext;
  logic [CW+PW-1:0]         occ_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign mode        = srq_pkg::mode_e'(req_i.mode);
  assign full        = (occ_q == CW'(DEPTH));
  assign empty       = (occ_q == '0);

  always_comb begin
    ctrl.key.stamp = req_i.stamp;
    ctrl.key.id    = req_i.requester;
    ctrl.ins       = (mode == srq_pkg::MODE_INSERT) && !full;
    ctrl.del       = (mode == srq_pkg::MODE_REMOVE) || (mode == srq_pkg::MODE_POP);
  end

  // pop starts the shift at the head, remove starts it at the first match
  assign seen[0] = (mode == srq_pkg::MODE_POP);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    srq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .ctrl_i     (ctrl),
      .valid_i    (occ_q > CW'(k)),
      .left_gt_i  ((k == 0) ? 1'b1 : gt[(k == 0) ? 0 : k-1]),
      .left_i     (ent[(k == 0) ? 0 : k-1]),
      .right_i    (ent[(k == DEPTH-1) ? k : k+1]),
      .seen_i     (seen[k]),
      .gt_o       (gt[k]),
      .ins_here_o (ins_here[k]),
      .first_o    (first[k]),
      .seen_o     (seen[k+1]),
      .entry_o    (ent[k])
    );
  end

  srq_enc #(.N(DEPTH), .W(IW)) u_ins_enc (.oh_i(ins_here), .idx_o(ins_idx));
  srq_enc #(.N(DEPTH), .W(IW)) u_rem_enc (.oh_i(first),    .idx_o(rem_idx));

  assign ins_ext = (IW+PW)'(ins_idx);
  assign rem_ext = (IW+PW)'(rem_idx);
  assign occ_ext = (CW+PW)'(occ_q);

  always_comb begin
    occ_d    = occ_q;
    status_d = srq_pkg::STAT_OK;
    pos_d    = '0;
    head_d   = '0;
    case (mode)
      srq_pkg::MODE_INSERT: begin
        if (full) begin
          status_d = srq_pkg::STAT_FULL;
        end else begin
          pos_d = ins_ext[PW-1:0];
          occ_d = occ_q + CW'(1);
        end
      end
      srq_pkg::MODE_REMOVE: begin
        if (seen[DEPTH]) begin
          pos_d = rem_ext[PW-1:0];
          occ_d = occ_q - CW'(1);
        end else begin
          status_d = srq_pkg::STAT_MISS;
        end
      end
      srq_pkg::MODE_POP: begin
        if (empty) begin
          status_d = srq_pkg::STAT_MISS;
        end else begin
          head_d = ent[0].id;
          occ_d  = occ_q - CW'(1);
        end
      end
      srq_pkg::MODE_CLEAR: begin
        pos_d = occ_ext[PW-1:0];
        occ_d = '0;
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pos_q    <= pos_d;
      head_q   <= head_d;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.position = pos_q;
  assign rsp_o.head_id  = head_q;

endmodule
